[rtl/core/tesd_pkg.sv]
// ----------------------------------------------------------------------------
// tesd_pkg
// Shared types and character constants for the terminal escape sequence
// decoder: command codes, parser tracker states and the result record.
// ----------------------------------------------------------------------------
package tesd_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;
  localparam int ARG_WIDTH_DEF    = 8;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;
  localparam int TUSER_OUT_W = 2;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_5      = 8'h35;
  localparam logic [7:0] CH_6      = 8'h36;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_UP_J   = 8'h4A;
  localparam logic [7:0] CH_UP_K   = 8'h4B;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LO_C   = 8'h63;
  localparam logic [7:0] CH_LO_H   = 8'h68;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_Q   = 8'h71;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  localparam logic [7:0] LED_NUM    = 8'd0;
  localparam logic [7:0] LED_CAPS   = 8'd1;
  localparam logic [7:0] LED_SCROLL = 8'd2;
  localparam logic [7:0] LED_OFF    = 8'd0;
  localparam logic [7:0] LED_ON     = 8'd1;

  typedef enum logic [4:0] {
    CMD_NONE       = 5'd0,
    CMD_IDENTIFY   = 5'd1,
    CMD_STATUS     = 5'd2,
    CMD_CURSOR_RPT = 5'd3,
    CMD_SIZE_RPT   = 5'd4,
    CMD_CLEAR      = 5'd5,
    CMD_CLEAR_EOL  = 5'd6,
    CMD_SHOW       = 5'd7,
    CMD_HIDE       = 5'd8,
    CMD_SAVE       = 5'd9,
    CMD_RESTORE    = 5'd10,
    CMD_SET_POS    = 5'd11,
    CMD_UP         = 5'd12,
    CMD_DOWN       = 5'd13,
    CMD_FWD        = 5'd14,
    CMD_BACK       = 5'd15,
    CMD_CLEAR_LEDS = 5'd16,
    CMD_LED        = 5'd17,
    CMD_UNKNOWN    = 5'd18
  } cmd_t;

  // prefix of the CSI body matched so far against the fixed forms
  typedef enum logic [3:0] {
    FX_EMPTY, FX_0, FX_1, FX_2, FX_3, FX_5, FX_6,
    FX_18, FX_21, FX_22, FX_23, FX_Q, FX_Q2, FX_Q25, FX_NONE
  } fixed_t;

  // shape of the CSI body as "digits ; digits"
  typedef enum logic [2:0] {
    NP_A0, NP_A, NP_S0, NP_B, NP_BAD
  } num_phase_t;

  typedef struct packed {
    logic       consumed;
    cmd_t       command;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic       aborted;
  } result_t;

endpackage

[rtl/core/tesd_parser.sv]
// ----------------------------------------------------------------------------
// tesd_parser
// Incremental escape sequence parser. Tracks length, the lead byte and the
// shape of a CSI body byte by byte, and decodes the sequence on its final
// byte. Result is combinational from the present state and char_in.
// ----------------------------------------------------------------------------
module tesd_parser #(
  parameter int BUFFER_DEPTH = tesd_pkg::BUFFER_DEPTH_DEF,
  parameter int ARG_WIDTH    = tesd_pkg::ARG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        char_in,
  output tesd_pkg::result_t result
);

  localparam int LEN_W = $clog2(BUFFER_DEPTH);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO  = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(BUFFER_DEPTH - 1);
  localparam logic [ARG_WIDTH-1:0] ARG_MAX = {ARG_WIDTH{1'b1}};

  logic [LEN_W-1:0]     len, len_next;
  logic [7:0]           lead, lead_next;
  tesd_pkg::fixed_t     fx, fx_next, fx_step;
  tesd_pkg::num_phase_t np, np_next;
  logic [ARG_WIDTH-1:0] arg_a, arg_a_next, arg_b, arg_b_next;
  logic [ARG_WIDTH-1:0] acc_digit;
  logic [ARG_WIDTH+7:0] ext_a, ext_b;
  logic                 is_digit;

  function automatic logic [ARG_WIDTH-1:0] sat_acc(input logic [ARG_WIDTH-1:0] v,
                                                    input logic [3:0] d);
    logic [ARG_WIDTH+3:0] t;
    t = {4'b0, v} * (ARG_WIDTH+4)'(10) + {{ARG_WIDTH{1'b0}}, d};
    if (t > {4'b0, ARG_MAX}) begin
      return ARG_MAX;
    end
    return t[ARG_WIDTH-1:0];
  endfunction

  assign is_digit = (char_in >= tesd_pkg::CH_0) && (char_in <= tesd_pkg::CH_9);
  assign ext_a    = {8'b0, arg_a};
  assign ext_b    = {8'b0, arg_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      fx  <= tesd_pkg::FX_EMPTY;
      np  <= tesd_pkg::NP_A0;
    end else if (step) begin
      len <= len_next;
      fx  <= fx_next;
      np  <= np_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lead  <= lead_next;
      arg_a <= arg_a_next;
      arg_b <= arg_b_next;
    end
  end

  // fixed-form prefix tracker
  always_comb begin
    fx_step = tesd_pkg::FX_NONE;
    case (fx)
      tesd_pkg::FX_EMPTY: begin
        case (char_in)
          tesd_pkg::CH_0:     fx_step = tesd_pkg::FX_0;
          tesd_pkg::CH_1:     fx_step = tesd_pkg::FX_1;
          tesd_pkg::CH_2:     fx_step = tesd_pkg::FX_2;
          tesd_pkg::CH_3:     fx_step = tesd_pkg::FX_3;
          tesd_pkg::CH_5:     fx_step = tesd_pkg::FX_5;
          tesd_pkg::CH_6:     fx_step = tesd_pkg::FX_6;
          tesd_pkg::CH_QMARK: fx_step = tesd_pkg::FX_Q;
          default:            fx_step = tesd_pkg::FX_NONE;
        endcase
      end
      tesd_pkg::FX_1: begin
        if (char_in == tesd_pkg::CH_8) fx_step = tesd_pkg::FX_18;
      end
      tesd_pkg::FX_2: begin
        case (char_in)
          tesd_pkg::CH_1: fx_step = tesd_pkg::FX_21;
          tesd_pkg::CH_2: fx_step = tesd_pkg::FX_22;
          tesd_pkg::CH_3: fx_step = tesd_pkg::FX_23;
          default:        fx_step = tesd_pkg::FX_NONE;
        endcase
      end
      tesd_pkg::FX_Q: begin
        if (char_in == tesd_pkg::CH_2) fx_step = tesd_pkg::FX_Q2;
      end
      tesd_pkg::FX_Q2: begin
        if (char_in == tesd_pkg::CH_5) fx_step = tesd_pkg::FX_Q25;
      end
      default: fx_step = tesd_pkg::FX_NONE;
    endcase
  end

  always_comb begin
    acc_digit  = '0;
    result     = '0;
    len_next   = len;
    lead_next  = lead;
    fx_next    = fx;
    np_next    = np;
    arg_a_next = arg_a;
    arg_b_next = arg_b;

    if (len == '0) begin
      if (char_in == tesd_pkg::CH_ESC) begin
        result.consumed = 1'b1;
        len_next        = LEN_ONE;
        fx_next         = tesd_pkg::FX_EMPTY;
        np_next         = tesd_pkg::NP_A0;
        arg_a_next      = '0;
        arg_b_next      = '0;
      end
    end else begin
      result.consumed = 1'b1;
      if (len == LEN_LAST || char_in[7]) begin
        result.aborted = 1'b1;
        len_next       = '0;
      end else if (len == LEN_ONE) begin
        lead_next = char_in;
        if (char_in >= tesd_pkg::CH_LT && char_in <= tesd_pkg::CH_UP_Z) begin
          len_next = '0;
          case (char_in)
            tesd_pkg::CH_UP_Z: result.command = tesd_pkg::CMD_IDENTIFY;
            tesd_pkg::CH_UP_A: result.command = tesd_pkg::CMD_UP;
            tesd_pkg::CH_UP_B: result.command = tesd_pkg::CMD_DOWN;
            tesd_pkg::CH_UP_C: result.command = tesd_pkg::CMD_FWD;
            tesd_pkg::CH_UP_D: result.command = tesd_pkg::CMD_BACK;
            default:           result.command = tesd_pkg::CMD_UNKNOWN;
          endcase
          if (char_in >= tesd_pkg::CH_UP_A && char_in <= tesd_pkg::CH_UP_D) begin
            result.arg_first = 8'd1;
          end
        end else begin
          len_next = len + LEN_ONE;
        end
      end else if (lead == tesd_pkg::CH_LBRACK) begin
        if (char_in >= tesd_pkg::CH_AT && char_in <= tesd_pkg::CH_TILDE) begin
          len_next       = '0;
          result.command = tesd_pkg::CMD_UNKNOWN;
          case (char_in)
            tesd_pkg::CH_LO_C: begin
              if (fx == tesd_pkg::FX_EMPTY || fx == tesd_pkg::FX_0) begin
                result.command = tesd_pkg::CMD_IDENTIFY;
              end
            end
            tesd_pkg::CH_LO_N: begin
              if (fx == tesd_pkg::FX_5) result.command = tesd_pkg::CMD_STATUS;
              if (fx == tesd_pkg::FX_6) result.command = tesd_pkg::CMD_CURSOR_RPT;
            end
            tesd_pkg::CH_LO_T: begin
              if (fx == tesd_pkg::FX_18) result.command = tesd_pkg::CMD_SIZE_RPT;
            end
            tesd_pkg::CH_UP_J: begin
              if (fx == tesd_pkg::FX_2) result.command = tesd_pkg::CMD_CLEAR;
            end
            tesd_pkg::CH_UP_K: begin
              if (fx == tesd_pkg::FX_EMPTY) result.command = tesd_pkg::CMD_CLEAR_EOL;
            end
            tesd_pkg::CH_LO_H: begin
              if (fx == tesd_pkg::FX_Q25) result.command = tesd_pkg::CMD_SHOW;
            end
            tesd_pkg::CH_LO_L: begin
              if (fx == tesd_pkg::FX_Q25) result.command = tesd_pkg::CMD_HIDE;
            end
            tesd_pkg::CH_LO_S: begin
              if (fx == tesd_pkg::FX_EMPTY) result.command = tesd_pkg::CMD_SAVE;
            end
            tesd_pkg::CH_LO_U: begin
              if (fx == tesd_pkg::FX_EMPTY) result.command = tesd_pkg::CMD_RESTORE;
            end
            tesd_pkg::CH_LO_Q: begin
              case (fx)
                tesd_pkg::FX_0: result.command = tesd_pkg::CMD_CLEAR_LEDS;
                tesd_pkg::FX_1: begin
                  result.command    = tesd_pkg::CMD_LED;
                  result.arg_first  = tesd_pkg::LED_NUM;
                  result.arg_second = tesd_pkg::LED_ON;
                end
                tesd_pkg::FX_2: begin
                  result.command    = tesd_pkg::CMD_LED;
                  result.arg_first  = tesd_pkg::LED_CAPS;
                  result.arg_second = tesd_pkg::LED_ON;
                end
                tesd_pkg::FX_3: begin
                  result.command    = tesd_pkg::CMD_LED;
                  result.arg_first  = tesd_pkg::LED_SCROLL;
                  result.arg_second = tesd_pkg::LED_ON;
                end
                tesd_pkg::FX_21: begin
                  result.command    = tesd_pkg::CMD_LED;
                  result.arg_first  = tesd_pkg::LED_NUM;
                  result.arg_second = tesd_pkg::LED_OFF;
                end
                tesd_pkg::FX_22: begin
                  result.command    = tesd_pkg::CMD_LED;
                  result.arg_first  = tesd_pkg::LED_CAPS;
                  result.arg_second = tesd_pkg::LED_OFF;
                end
                tesd_pkg::FX_23: begin
                  result.command    = tesd_pkg::CMD_LED;
                  result.arg_first  = tesd_pkg::LED_SCROLL;
                  result.arg_second = tesd_pkg::LED_OFF;
                end
                default: result.command = tesd_pkg::CMD_UNKNOWN;
              endcase
            end
            tesd_pkg::CH_UP_A, tesd_pkg::CH_UP_B, tesd_pkg::CH_UP_C,
            tesd_pkg::CH_UP_D: begin
              if (np == tesd_pkg::NP_A) begin
                result.arg_first = ext_a[7:0];
                case (char_in)
                  tesd_pkg::CH_UP_A: result.command = tesd_pkg::CMD_UP;
                  tesd_pkg::CH_UP_B: result.command = tesd_pkg::CMD_DOWN;
                  tesd_pkg::CH_UP_C: result.command = tesd_pkg::CMD_FWD;
                  default:           result.command = tesd_pkg::CMD_BACK;
                endcase
              end
            end
            tesd_pkg::CH_UP_H: begin
              if (np == tesd_pkg::NP_B) begin
                result.command    = tesd_pkg::CMD_SET_POS;
                result.arg_first  = ext_a[7:0];
                result.arg_second = ext_b[7:0];
              end
            end
            default: result.command = tesd_pkg::CMD_UNKNOWN;
          endcase
        end else begin
          len_next = len + LEN_ONE;
          fx_next  = fx_step;
          case (np)
            tesd_pkg::NP_A0, tesd_pkg::NP_A: begin
              acc_digit = sat_acc(arg_a, char_in[3:0]);
              if (is_digit) begin
                np_next    = tesd_pkg::NP_A;
                arg_a_next = acc_digit;
              end else if (np == tesd_pkg::NP_A && char_in == tesd_pkg::CH_SEMI) begin
                np_next = tesd_pkg::NP_S0;
              end else begin
                np_next = tesd_pkg::NP_BAD;
              end
            end
            tesd_pkg::NP_S0, tesd_pkg::NP_B: begin
              acc_digit = sat_acc(arg_b, char_in[3:0]);
              if (is_digit) begin
                np_next    = tesd_pkg::NP_B;
                arg_b_next = acc_digit;
              end else begin
                np_next = tesd_pkg::NP_BAD;
              end
            end
            default: np_next = tesd_pkg::NP_BAD;
          endcase
        end
      end else if (len == LEN_TWO &&
                   (lead == tesd_pkg::CH_LPAREN || lead == tesd_pkg::CH_RPAREN)) begin
        // character set designation: complete but not decoded
        len_next       = '0;
        result.command = tesd_pkg::CMD_UNKNOWN;
      end else begin
        len_next = len + LEN_ONE;
      end
    end
  end

endmodule

[rtl/core/terminal_escape_sequence_decoder_unit.sv]
// ----------------------------------------------------------------------------
// terminal_escape_sequence_decoder_unit
// Decodes VT100/ANSI escape sequences from a received character stream,
// one character per beat, into command codes with decimal arguments.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                          | tuser
//  s_*     | in  | [7:0] char_in                                  | -
//  m_*     | out | [4:0] command, [12:5] arg_first,               | [0] consumed,
//          |     | [20:13] arg_second, [23:21] zero               | [1] aborted
//
//  One result beat for every input beat, valid in the cycle after its beat
//  is taken; a new beat is taken every cycle while s_tready is high. The
//  parser state updates as the beat is taken and the result lands in the
//  output register. s_tready is low only while a result is held and
//  m_tready is low. rst clears the sequence length and the output valid.
// ----------------------------------------------------------------------------
module terminal_escape_sequence_decoder_unit #(
  parameter int BUFFER_DEPTH = tesd_pkg::BUFFER_DEPTH_DEF,
  parameter int ARG_WIDTH    = tesd_pkg::ARG_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tesd_pkg::TDATA_IN_W-1:0]  s_tdata,  // [7:0] char_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tesd_pkg::TDATA_OUT_W-1:0] m_tdata,  // command, arg_first, arg_second
  output logic [tesd_pkg::TUSER_OUT_W-1:0] m_tuser   // consumed, aborted
);

  logic              step;
  tesd_pkg::result_t res_comb;
  tesd_pkg::result_t res;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  tesd_parser #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .ARG_WIDTH    (ARG_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .char_in (s_tdata),
    .result  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_comb;
    end
  end

  assign m_tdata = {3'b000, res.arg_second, res.arg_first, res.command};
  assign m_tuser = {res.aborted, res.consumed};

endmodule
